>>> hw/rtl/fpda_pkg.sv
// Package for the fixed-point to decimal ASCII converter.
// Beat types, field widths and character constants; no dependencies.
package fpda_pkg;

  localparam int ValueWidth = 16;
  localparam int FracBitsW  = 4;
  localparam int FracDigW   = 3;
  localparam int CharW      = 7;
  localparam int BcdDigits  = 5;
  localparam int BcdW       = 4 * BcdDigits;
  localparam int RemW       = ValueWidth - 1;
  localparam int ProdW      = RemW + 4;
  localparam int CntW       = $clog2(ValueWidth + 1);

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharPoint = 7'h2E;
  localparam logic [3:0]       Radix     = 4'd10;

  typedef struct packed {
    logic [ValueWidth-1:0] value_bits;
    logic                  is_signed;
    logic [FracBitsW-1:0]  frac_bits;
    logic [FracDigW-1:0]   frac_digits;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } out_beat_t;

  typedef enum logic [1:0] {
    BcdHold,
    BcdLoad,
    BcdStep,
    BcdShift
  } bcd_op_e;

  typedef enum logic [1:0] {
    FracHold,
    FracLoad,
    FracStep
  } frac_op_e;

  typedef struct packed {
    bcd_op_e               op;
    logic [ValueWidth-1:0] bin;
  } bcd_ctrl_t;

  typedef struct packed {
    frac_op_e             op;
    logic [RemW-1:0]      rem;
    logic [FracBitsW-1:0] fb;
  } frac_ctrl_t;

endpackage

>>> hw/rtl/fixed_point_to_decimal_ascii.sv
// Fixed-point to decimal ASCII converter, top level. Uses fpda_pkg, fpda_dabble, fpda_frac.
// Sequence: bit-serial BCD conversion, a trim of leading zero integer digits, then one
// char per cycle while the output is not stalled; each char is registered.
// A new value is taken only in idle, after the bit-serial BCD loop and every char (up to 11)
// of the last value are done; the next value is taken while the last char waits.
// Reset: asynchronous, clears the sequencer and the output valid.
module fixed_point_to_decimal_ascii #(
  parameter int MAX_FRAC_DIGITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpda_pkg::in_beat_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fpda_pkg::out_beat_t out_data_o
);

  localparam int NdW = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int StW = 3;

  localparam logic [StW-1:0] SIdle  = 3'd0;
  localparam logic [StW-1:0] SConv  = 3'd1;
  localparam logic [StW-1:0] STrim  = 3'd2;
  localparam logic [StW-1:0] SSign  = 3'd3;
  localparam logic [StW-1:0] SInt   = 3'd4;
  localparam logic [StW-1:0] SPoint = 3'd5;
  localparam logic [StW-1:0] SFrac  = 3'd6;

  logic [StW-1:0]                  state_q, state_d;
  logic [fpda_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            neg_q, neg_d;
  logic [NdW-1:0]                  nd_q, nd_d;
  logic [fpda_pkg::FracBitsW-1:0]  fb_q, fb_d;
  logic                            out_valid_q, out_valid_d;
  fpda_pkg::out_beat_t             out_data_q, out_data_d;

  logic                            accept;
  logic                            out_free;
  logic                            in_neg;
  logic [fpda_pkg::ValueWidth-1:0] mag;
  logic [fpda_pkg::ValueWidth-1:0] fmask;
  logic [NdW-1:0]                  nd_sat;
  logic [3:0]                      int_digit;
  logic [3:0]                      frac_digit;
  fpda_pkg::bcd_ctrl_t             bcd_ctrl;
  fpda_pkg::frac_ctrl_t            frac_ctrl;

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_neg = in_data_i.is_signed && in_data_i.value_bits[fpda_pkg::ValueWidth-1];
  assign mag    = in_neg ? (fpda_pkg::ValueWidth'(0) - in_data_i.value_bits)
                         : in_data_i.value_bits;
  assign fmask  = (fpda_pkg::ValueWidth'(1) << in_data_i.frac_bits) - fpda_pkg::ValueWidth'(1);
  assign nd_sat = (32'(in_data_i.frac_digits) > MAX_FRAC_DIGITS) ? NdW'(MAX_FRAC_DIGITS)
                                                                 : NdW'(in_data_i.frac_digits);

  fpda_dabble u_dabble (
    .clk_i       (clk_i),
    .ctrl_i      (bcd_ctrl),
    .top_digit_o (int_digit)
  );

  fpda_frac u_frac (
    .clk_i   (clk_i),
    .ctrl_i  (frac_ctrl),
    .digit_o (frac_digit)
  );

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    neg_d          = neg_q;
    nd_d           = nd_q;
    fb_d           = fb_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_data_d     = out_data_q;
    bcd_ctrl.op    = fpda_pkg::BcdHold;
    bcd_ctrl.bin   = mag >> in_data_i.frac_bits;
    frac_ctrl.op   = fpda_pkg::FracHold;
    frac_ctrl.rem  = fpda_pkg::RemW'(mag & fmask);
    frac_ctrl.fb   = fb_q;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          bcd_ctrl.op  = fpda_pkg::BcdLoad;
          frac_ctrl.op = fpda_pkg::FracLoad;
          neg_d        = in_neg;
          nd_d         = nd_sat;
          fb_d         = in_data_i.frac_bits;
          cnt_d        = fpda_pkg::CntW'(fpda_pkg::ValueWidth);
          state_d      = SConv;
        end
      end
      SConv: begin
        bcd_ctrl.op = fpda_pkg::BcdStep;
        cnt_d       = cnt_q - fpda_pkg::CntW'(1);
        if (cnt_q == fpda_pkg::CntW'(1)) begin
          cnt_d   = fpda_pkg::CntW'(fpda_pkg::BcdDigits);
          state_d = STrim;
        end
      end
      STrim: begin
        if (int_digit == 4'd0 && cnt_q != fpda_pkg::CntW'(1)) begin
          bcd_ctrl.op = fpda_pkg::BcdShift;
          cnt_d       = cnt_q - fpda_pkg::CntW'(1);
        end else begin
          state_d = neg_q ? SSign : SInt;
        end
      end
      SSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{char_code: fpda_pkg::CharMinus, last_char: 1'b0};
          state_d     = SInt;
        end
      end
      SInt: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{char_code: fpda_pkg::CharZero + fpda_pkg::CharW'(int_digit),
                          last_char: (cnt_q == fpda_pkg::CntW'(1)) && (nd_q == '0)};
          bcd_ctrl.op = fpda_pkg::BcdShift;
          cnt_d       = cnt_q - fpda_pkg::CntW'(1);
          if (cnt_q == fpda_pkg::CntW'(1)) begin
            state_d = (nd_q == '0) ? SIdle : SPoint;
          end
        end
      end
      SPoint: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{char_code: fpda_pkg::CharPoint, last_char: 1'b0};
          cnt_d       = fpda_pkg::CntW'(nd_q);
          state_d     = SFrac;
        end
      end
      SFrac: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = '{char_code: fpda_pkg::CharZero + fpda_pkg::CharW'(frac_digit),
                           last_char: (cnt_q == fpda_pkg::CntW'(1))};
          frac_ctrl.op = fpda_pkg::FracStep;
          cnt_d        = cnt_q - fpda_pkg::CntW'(1);
          if (cnt_q == fpda_pkg::CntW'(1)) begin
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    nd_q       <= nd_d;
    fb_q       <= fb_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/fpda_dabble.sv
// Bit-serial binary to BCD converter (shift-and-add-3), one bit per step,
// with a digit shift to trim and emit digits MSB first. Uses fpda_pkg.
module fpda_dabble (
  input  logic                clk_i,
  input  fpda_pkg::bcd_ctrl_t ctrl_i,
  output logic [3:0]          top_digit_o
);

  logic [fpda_pkg::ValueWidth-1:0] bin_q, bin_d;
  logic [fpda_pkg::BcdW-1:0]       bcd_q, bcd_d;
  logic [fpda_pkg::BcdW-1:0]       adj;

  always_comb begin
    for (int i = 0; i < fpda_pkg::BcdDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    case (ctrl_i.op)
      fpda_pkg::BcdLoad: begin
        bin_d = ctrl_i.bin;
        bcd_d = '0;
      end
      fpda_pkg::BcdStep: begin
        bcd_d = {adj[fpda_pkg::BcdW-2:0], bin_q[fpda_pkg::ValueWidth-1]};
        bin_d = {bin_q[fpda_pkg::ValueWidth-2:0], 1'b0};
      end
      fpda_pkg::BcdShift: begin
        bcd_d = {bcd_q[fpda_pkg::BcdW-5:0], 4'b0000};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[fpda_pkg::BcdW-1 -: 4];

endmodule

>>> hw/rtl/fpda_frac.sv
// Fraction digit generator: each step multiplies the remainder by ten and
// splits off one decimal digit above the binary point. Uses fpda_pkg.
module fpda_frac (
  input  logic                 clk_i,
  input  fpda_pkg::frac_ctrl_t ctrl_i,
  output logic [3:0]           digit_o
);

  logic [fpda_pkg::RemW-1:0]  rem_q, rem_d;
  logic [fpda_pkg::ProdW-1:0] prod;
  logic [fpda_pkg::ProdW-1:0] mask;

  assign prod    = fpda_pkg::ProdW'(rem_q) * fpda_pkg::ProdW'(fpda_pkg::Radix);
  assign mask    = (fpda_pkg::ProdW'(1) << ctrl_i.fb) - fpda_pkg::ProdW'(1);
  assign digit_o = 4'(prod >> ctrl_i.fb);

  always_comb begin
    rem_d = rem_q;
    case (ctrl_i.op)
      fpda_pkg::FracLoad: rem_d = ctrl_i.rem;
      fpda_pkg::FracStep: rem_d = fpda_pkg::RemW'(prod & mask);
      default:            rem_d = rem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

endmodule
